/* design/btsp_pkg.sv */
package btsp_pkg;

  // Parse phase; the first five codes double as byte kinds
  typedef enum logic [2:0] {
    PH_TAG_FIRST = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_VALUE     = 3'd4
  } btsp_phase_e;

  localparam logic [2:0] KIND_VALUE = 3'd4;
  localparam logic [2:0] KIND_EOC   = 3'd5;
  localparam logic [2:0] KIND_END   = 3'd6;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TRUNC    = 3'd1;
  localparam logic [2:0] ERR_TAG_LONG = 3'd2;
  localparam logic [2:0] ERR_LEN_LONG = 3'd3;
  localparam logic [2:0] ERR_OVERRUN  = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;

  localparam logic [4:0] LOW_TAG     = 5'h1F;
  localparam logic [7:0] INDEF_LEN   = 8'h80;
  localparam logic [31:0] LIMIT_RESET = 32'd1048576;

  localparam int          APB_ADDR_W     = 2;
  localparam logic [1:0]  ADDR_TOP_LIMIT = 2'd0;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [4:0]  nesting_depth;
    logic [1:0]  tag_class;
    logic        is_constructed;
    logic [27:0] tag_number;
    logic [31:0] content_length;
    logic        is_indefinite;
    logic        header_complete;
    logic [4:0]  levels_closed;
    logic [2:0]  error_code;
  } btsp_result_t;

endpackage

/* design/btsp_in_if.sv */
interface btsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

/* design/btsp_out_if.sv */
interface btsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [4:0]  nesting_depth;
  logic [1:0]  tag_class;
  logic        is_constructed;
  logic [27:0] tag_number;
  logic [31:0] content_length;
  logic        is_indefinite;
  logic        header_complete;
  logic [4:0]  levels_closed;
  logic [2:0]  error_code;

  modport source (
    output valid, byte_kind, nesting_depth, tag_class, is_constructed, tag_number,
           content_length, is_indefinite, header_complete, levels_closed, error_code,
    input  ready
  );
  modport sink (
    input  valid, byte_kind, nesting_depth, tag_class, is_constructed, tag_number,
           content_length, is_indefinite, header_complete, levels_closed, error_code,
    output ready
  );
endinterface

/* design/ber_tlv_stream_parser.sv */
// BER TLV byte labeller.
// s_item_i carries one stream byte per item (data_byte) or an end-of-stream
// marker (end_of_stream). m_item_o returns exactly one label per item: byte
// kind, nesting depth, header fields decoded so far, levels closed by the byte
// and a sticky error code. Both channels use valid/ready; an item moves on a
// clock edge where both are high.
// An accepted item passes the input register, then the result register, on
// its way to m_item_o. Throughput: one item per cycle while m_item_o does not
// stall; the decode and the parallel compare of every open stack level
// against the byte position fit between the two registers, so nothing
// iterates.
// A stall on m_item_o holds the result register; the input register still
// takes one more item and then s_item_i.ready drops until the result leaves.
// The APB port holds top_limit (byte address 0), the largest size of one
// top-level element; write it only while the parser is idle.
// Reset (rst_ni low) empties both registers, returns the parser to the start
// of a tag and sets top_limit to 1048576. An end-of-stream item resets the
// parser in the same way but keeps top_limit.
module ber_tlv_stream_parser
  import btsp_pkg::*;
#(
  parameter int STACK_DEPTH    = 16,
  parameter int MAX_LEN_OCTETS = 4,
  parameter int MAX_TAG_GROUPS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  btsp_in_if.sink               s_item_i,
  btsp_out_if.source            m_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TG_W  = $clog2(MAX_TAG_GROUPS + 2);
  localparam int OL_W  = $clog2(MAX_LEN_OCTETS + 1);
  localparam int CL_W  = SP_W + 1;

  // configuration
  logic [31:0] top_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_TOP_LIMIT) begin
      top_limit_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TOP_LIMIT) ? top_limit_q : 32'd0;

  // pipeline handshake
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_eos_q;
  logic         out_valid_q;
  btsp_result_t out_q;
  btsp_result_t res;
  logic         advance;

  assign advance        = in_valid_q && (!out_valid_q || m_item_o.ready);
  assign s_item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_item_i.ready) begin
        in_valid_q <= s_item_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_item_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_item_i.ready && s_item_i.valid) begin
      in_byte_q <= s_item_i.data_byte;
      in_eos_q  <= s_item_i.end_of_stream;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_item_o.valid           = out_valid_q;
  assign m_item_o.byte_kind       = out_q.byte_kind;
  assign m_item_o.nesting_depth   = out_q.nesting_depth;
  assign m_item_o.tag_class       = out_q.tag_class;
  assign m_item_o.is_constructed  = out_q.is_constructed;
  assign m_item_o.tag_number      = out_q.tag_number;
  assign m_item_o.content_length  = out_q.content_length;
  assign m_item_o.is_indefinite   = out_q.is_indefinite;
  assign m_item_o.header_complete = out_q.header_complete;
  assign m_item_o.levels_closed   = out_q.levels_closed;
  assign m_item_o.error_code      = out_q.error_code;

  // parser state
  btsp_phase_e       phase_q, phase_d;
  logic [27:0]       tag_q, tag_d;
  logic [1:0]        cls_q, cls_d;
  logic              cons_q, cons_d;
  logic              indef_q, indef_d;
  logic [31:0]       len_q, len_d;
  logic [OL_W-1:0]   oct_q, oct_d;
  logic [31:0]       vleft_q, vleft_d;
  logic [31:0]       pos_q, pos_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [2:0]        err_q, err_d;
  logic [TG_W-1:0]   tgrp_q, tgrp_d;
  logic              eoc_q, eoc_d;

  // open levels, valid only below sp_q
  logic [31:0]       lvl_end_q   [STACK_DEPTH];
  logic              lvl_indef_q [STACK_DEPTH];
  logic              push;
  logic [IDX_W-1:0]  push_idx;
  logic [31:0]       push_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG_FIRST;
      tag_q   <= '0;
      cls_q   <= '0;
      cons_q  <= 1'b0;
      indef_q <= 1'b0;
      len_q   <= '0;
      oct_q   <= '0;
      vleft_q <= '0;
      pos_q   <= '0;
      sp_q    <= '0;
      err_q   <= ERR_NONE;
      tgrp_q  <= '0;
      eoc_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      cls_q   <= cls_d;
      cons_q  <= cons_d;
      indef_q <= indef_d;
      len_q   <= len_d;
      oct_q   <= oct_d;
      vleft_q <= vleft_d;
      pos_q   <= pos_d;
      sp_q    <= sp_d;
      err_q   <= err_d;
      tgrp_q  <= tgrp_d;
      eoc_q   <= eoc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && push) begin
      lvl_end_q[push_idx]   <= push_end;
      lvl_indef_q[push_idx] <= indef_d;
    end
  end

  logic [7:0]        b;
  logic [32:0]       pos_inc;
  logic [33:0]       end_ext;
  logic [34:0]       tag_sh;
  logic [39:0]       len_sh;
  logic [31:0]       vdec;
  logic [2:0]        kind;
  logic [2:0]        err;
  logic              hc;
  logic              done;
  logic              early_err;
  logic              top_indef;
  logic              carry;
  logic              run;
  logic [SP_W-1:0]   sp_mid;
  logic [SP_W-1:0]   pops;
  logic [CL_W-1:0]   closed;

  assign b        = in_byte_q;
  assign pos_inc  = {1'b0, pos_q} + 33'd1;
  assign push_idx = sp_q[IDX_W-1:0];
  assign push_end = end_ext[31:0];

  always_comb begin
    phase_d   = phase_q;
    tag_d     = tag_q;
    cls_d     = cls_q;
    cons_d    = cons_q;
    indef_d   = indef_q;
    len_d     = len_q;
    oct_d     = oct_q;
    vleft_d   = vleft_q;
    pos_d     = pos_q;
    sp_d      = sp_q;
    err_d     = err_q;
    tgrp_d    = tgrp_q;
    eoc_d     = eoc_q;
    kind      = phase_q;
    err       = ERR_NONE;
    hc        = 1'b0;
    done      = 1'b0;
    push      = 1'b0;
    sp_mid    = sp_q;
    pops      = '0;
    closed    = '0;
    end_ext   = '0;
    tag_sh    = {tag_q, b[6:0]};
    len_sh    = {len_q, b};
    vdec      = (vleft_q != 32'd0) ? vleft_q - 32'd1 : 32'd0;
    top_indef = (sp_q != '0) ? lvl_indef_q[IDX_W'(sp_q - SP_W'(1))] : 1'b0;
    carry     = 1'b1;
    run       = 1'b0;
    res       = '0;

    // byte at or past the end of an open definite level or the top limit
    early_err = pos_q >= top_limit_q;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (sp_q > SP_W'(i) && !lvl_indef_q[i] && lvl_end_q[i] <= pos_q) begin
        early_err = 1'b1;
      end
    end

    if (in_eos_q) begin
      phase_d = PH_TAG_FIRST;
      tag_d   = '0;
      cls_d   = '0;
      cons_d  = 1'b0;
      indef_d = 1'b0;
      len_d   = '0;
      oct_d   = '0;
      vleft_d = '0;
      pos_d   = '0;
      sp_d    = '0;
      err_d   = ERR_NONE;
      tgrp_d  = '0;
      eoc_d   = 1'b0;
      res.byte_kind = KIND_END;
      if (err_q != ERR_NONE) begin
        res.error_code = err_q;
      end else if (phase_q != PH_TAG_FIRST || sp_q != '0) begin
        res.error_code = ERR_TRUNC;
      end else begin
        res.error_code = ERR_NONE;
      end
    end else if (err_q != ERR_NONE) begin
      res.byte_kind  = KIND_VALUE;
      res.error_code = err_q;
    end else begin
      if (early_err) begin
        err = ERR_OVERRUN;
      end else begin
        case (phase_q)
          PH_TAG_FIRST: begin
            cls_d   = b[7:6];
            cons_d  = b[5];
            indef_d = 1'b0;
            len_d   = '0;
            eoc_d   = (b == 8'd0);
            if (b[4:0] == LOW_TAG) begin
              tag_d   = '0;
              tgrp_d  = '0;
              phase_d = PH_TAG_MORE;
            end else begin
              tag_d   = {23'd0, b[4:0]};
              phase_d = PH_LEN_FIRST;
            end
          end
          PH_TAG_MORE: begin
            tgrp_d = tgrp_q + TG_W'(1);
            if (tgrp_q >= TG_W'(MAX_TAG_GROUPS)) begin
              err = ERR_TAG_LONG;
            end else begin
              tag_d = tag_sh[27:0];
              if (tag_sh[34:28] != 7'd0) begin
                err = ERR_TAG_LONG;
              end else if (!b[7]) begin
                phase_d = PH_LEN_FIRST;
              end
            end
          end
          PH_LEN_FIRST: begin
            if (eoc_q && b == 8'd0 && sp_q != '0 && top_indef) begin
              // end-of-contents closes the innermost indefinite level
              kind    = KIND_EOC;
              sp_mid  = sp_q - SP_W'(1);
              closed  = CL_W'(1);
              done    = 1'b1;
              phase_d = PH_TAG_FIRST;
            end else if (b == INDEF_LEN) begin
              if (!cons_q) begin
                err = ERR_LEN_LONG;
              end else begin
                indef_d = 1'b1;
                hc      = 1'b1;
              end
            end else if (b[7]) begin
              if (b[6:0] > 7'(MAX_LEN_OCTETS)) begin
                err = ERR_LEN_LONG;
              end else begin
                oct_d   = OL_W'(b[6:0]);
                len_d   = '0;
                phase_d = PH_LEN_MORE;
              end
            end else begin
              len_d = {24'd0, b};
              hc    = 1'b1;
            end
          end
          PH_LEN_MORE: begin
            len_d = len_sh[31:0];
            if (len_sh[39:32] != 8'd0) begin
              err = ERR_LEN_LONG;
            end else begin
              oct_d = oct_q - OL_W'(1);
              if (oct_q == OL_W'(1)) begin
                hc = 1'b1;
              end
            end
          end
          PH_VALUE: begin
            vleft_d = vdec;
            if (vdec == 32'd0) begin
              done    = 1'b1;
              phase_d = PH_TAG_FIRST;
            end
          end
          default: begin
            phase_d = PH_TAG_FIRST;
          end
        endcase
      end

      // header finished: check its end and open, close or start the value
      if (err == ERR_NONE && hc) begin
        phase_d = PH_TAG_FIRST;
        if (!indef_d) begin
          end_ext = {2'b00, pos_q} + 34'd1 + {2'b00, len_d};
          if (end_ext > {2'b00, top_limit_q}) begin
            err = ERR_OVERRUN;
          end
          for (int i = 0; i < STACK_DEPTH; i++) begin
            if (sp_q > SP_W'(i) && !lvl_indef_q[i] && end_ext > {2'b00, lvl_end_q[i]}) begin
              err = ERR_OVERRUN;
            end
          end
        end
        if (err == ERR_NONE) begin
          if (cons_d && (indef_d || len_d != 32'd0)) begin
            if (sp_q >= SP_W'(STACK_DEPTH)) begin
              err = ERR_OVERFLOW;
            end else begin
              push   = 1'b1;
              sp_mid = sp_q + SP_W'(1);
            end
          end else if (cons_d) begin
            closed = CL_W'(1);
            done   = 1'b1;
          end else if (len_d != 32'd0) begin
            vleft_d = len_d;
            phase_d = PH_VALUE;
          end else begin
            done = 1'b1;
          end
        end
      end

      if (err != ERR_NONE) begin
        err_d  = err;
        hc     = 1'b0;
        closed = '0;
        done   = 1'b0;
        push   = 1'b0;
      end

      // close every definite level, innermost first, that ends with this byte
      for (int i = STACK_DEPTH - 1; i >= 0; i--) begin
        if (sp_mid > SP_W'(i)) begin
          run   = carry && !lvl_indef_q[i] && ({1'b0, lvl_end_q[i]} == pos_inc);
          carry = run;
          if (run) begin
            pops = pops + SP_W'(1);
          end
        end
      end

      if (done) begin
        sp_d   = sp_mid - pops;
        closed = closed + CL_W'(pops);
      end else begin
        sp_d = sp_mid;
      end
      pos_d = (done && sp_d == '0) ? 32'd0 : pos_inc[31:0];

      res.byte_kind       = kind;
      res.nesting_depth   = 5'(sp_q);
      res.tag_class       = cls_d;
      res.is_constructed  = cons_d;
      res.tag_number      = tag_d;
      res.content_length  = len_d;
      res.is_indefinite   = indef_d;
      res.header_complete = hc;
      res.levels_closed   = 5'(closed);
      res.error_code      = err;
    end
  end

endmodule
